// File: rtl/ist_pkg.sv
// Package for the integer set table: operation and status codes, the sequencer
// state type and the control word given to each storage cell.
// No dependencies.
package ist_pkg;

  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_FIND   = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_BAD_POS   = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // per-cell control: compare strobe, occupancy, load key, take neighbour
  typedef struct packed {
    logic cmp;
    logic live;
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

// File: rtl/ist_cell.sv
// One storage cell of the set table: holds an element, compares it with the
// broadcast key and can take its upper neighbour's element on a removal.
// Depends on ist_pkg.
module ist_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  ist_pkg::cell_ctl_t            ctl,
  input  logic [ist_pkg::DATA_W-1:0]    key,
  input  logic [ist_pkg::DATA_W-1:0]    upper,
  output logic [ist_pkg::DATA_W-1:0]    data,
  output logic                          hit
);
  import ist_pkg::*;

  // element: payload, no reset
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data <= key;
    end else if (ctl.shift) begin
      data <= upper;
    end
  end

  // match flag captured when a request is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctl.cmp) begin
      hit <= ctl.live && (data == key);
    end
  end

endmodule

// File: rtl/ist_enc.sv
// One-hot to binary encoder with an any-bit, used to turn the row of cell
// match flags into a position.
// No dependencies.
module ist_enc #(
  parameter int N = 64,
  parameter int W = 6
) (
  input  logic [N-1:0] onehot,
  output logic [W-1:0] index,
  output logic         any
);

  always_comb begin
    index = '0;
    for (int i = 0; i < N; i++) begin
      if (onehot[i]) begin
        index = index | W'(i);
      end
    end
    any = |onehot;
  end

endmodule

// File: rtl/integer_set_table.sv
// Top level of the integer set table: a row of compare/shift cells, the
// position encoder and a two-state sequencer with a registered result.
// Depends on ist_pkg, ist_cell, ist_enc.
//
//  channel | direction | tuser          | tdata (lowest bit first)
//  --------+-----------+----------------+-----------------------------------------
//  s_axis  | in        | kind[1:0]      | value[31:0], position[37:32], pad to 40
//  m_axis  | out       | status[2:0]    | found_position[5:0], read_value[37:6],
//          |           |                | count[44:38], pad to 48
//
// The transfer edge latches the request and every cell's match flag; the execute
// step then encodes the hit, applies the insert or the one-place shift of a
// removal, and loads the result register.
// The second step waits while a previous result is still held and not taken,
// so one result may wait in the output register while the next request is in.
// rst (synchronous, active high) empties the set and drops any pending result;
// element storage is not cleared, only cells below the count are ever used.
module integer_set_table #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // value[31:0], position[37:32]
  input  logic [1:0]  s_axis_tuser,   // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // found_position[5:0], read_value[37:6], count[44:38]
  output logic [2:0]  m_axis_tuser    // status[2:0]
);
  import ist_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;  // cell index width
  localparam int HW = $clog2(CAPACITY + 1);                    // element count width
  localparam int CW = (HW > 6) ? HW : 6;                       // position compare width

  // sequencer and latched request
  state_t              state, state_next;
  kind_t               kind;
  logic [DATA_W-1:0]   key;
  logic [5:0]          pos;
  logic [HW-1:0]       held, held_next;

  // cell row
  cell_ctl_t           ctl   [CAPACITY];
  logic [DATA_W-1:0]   data  [CAPACITY];
  logic [DATA_W-1:0]   upper [CAPACITY];
  logic [CAPACITY-1:0] hits;
  logic [DATA_W-1:0]   cell_key;

  // encoder
  logic [IW-1:0]       at;
  logic                found;

  // execute-step decisions
  logic                in_xfer, out_free, done;
  logic                ins_do, rem_do, read_ok;
  logic [CW-1:0]       pos_ext, held_ext;
  status_t             status_res;
  logic [5:0]          fpos_res;
  logic [DATA_W-1:0]   rval_res;

  // result register
  status_t             status_q;
  logic [5:0]          fpos_q;
  logic [DATA_W-1:0]   rval_q;
  logic [6:0]          count_q;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign done     = (state == S_EXEC) && out_free;

  // compare against the incoming value, load from the latched one
  assign cell_key = (state == S_IDLE) ? s_axis_tdata[31:0] : key;

  ist_enc #(.N(CAPACITY), .W(IW)) u_enc (
    .onehot (hits),
    .index  (at),
    .any    (found)
  );

  assign ins_do   = done && (kind == KIND_INSERT) && !found && (held < HW'(CAPACITY));
  assign rem_do   = done && (kind == KIND_REMOVE) && (held != '0) && found;
  assign pos_ext  = CW'(pos);
  assign held_ext = CW'(held);
  assign read_ok  = pos_ext < held_ext;

  // cell row: each cell looks only at its own index and its upper neighbour
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_comb begin
      ctl[i].cmp   = in_xfer;
      ctl[i].live  = HW'(i) < held;
      ctl[i].load  = ins_do && (HW'(i) == held);
      ctl[i].shift = rem_do && (IW'(i) >= at);
    end

    if (i == CAPACITY - 1) begin : g_top
      assign upper[i] = data[i];
    end else begin : g_mid
      assign upper[i] = data[i+1];
    end

    ist_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl[i]),
      .key   (cell_key),
      .upper (upper[i]),
      .data  (data[i]),
      .hit   (hits[i])
    );
  end

  // result of the current request
  always_comb begin
    status_res = ST_OK;
    fpos_res   = '0;
    rval_res   = '0;
    held_next  = held;
    case (kind)
      KIND_INSERT: begin
        if (found) begin
          status_res = ST_PRESENT;
        end else if (held >= HW'(CAPACITY)) begin
          status_res = ST_FULL;
        end else begin
          held_next = held + HW'(1);
        end
      end
      KIND_REMOVE: begin
        if (held == '0) begin
          status_res = ST_EMPTY;
        end else if (!found) begin
          status_res = ST_NOT_FOUND;
        end else begin
          held_next = held - HW'(1);
        end
      end
      KIND_FIND: begin
        if (found) begin
          fpos_res = 6'(at);
        end else begin
          status_res = ST_NOT_FOUND;
        end
      end
      KIND_READ: begin
        if (read_ok) begin
          // AND-OR select across the row
          for (int i = 0; i < CAPACITY; i++) begin
            if (CW'(i) == pos_ext) begin
              rval_res = rval_res | data[i];
            end
          end
        end else begin
          status_res = ST_BAD_POS;
        end
      end
      default: begin
        status_res = ST_OK;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      held  <= '0;
    end else begin
      state <= state_next;
      if (done) begin
        held <= held_next;
      end
    end
  end

  // request latch: payload only
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind <= kind_t'(s_axis_tuser);
      key  <= s_axis_tdata[31:0];
      pos  <= s_axis_tdata[37:32];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (done) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      status_q <= status_res;
      fpos_q   <= fpos_res;
      rval_q   <= rval_res;
      count_q  <= 7'(held_next);
    end
  end

  assign m_axis_tuser = status_q;
  assign m_axis_tdata = {3'b000, count_q, rval_q, fpos_q};

`ifndef SYNTHESIS
  // count never passes the capacity
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= HW'(CAPACITY))
    else $error("element count above capacity");

  // elements are distinct, so at most one cell can match
  a_hit_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hits))
    else $error("more than one cell matched the key");

  // a taken request always moves to the execute step
  a_xfer_exec: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> state == S_EXEC)
    else $error("request transfer did not enter execute");

  // count changes only when a request completes
  a_held_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(held) |-> $past(done))
    else $error("count changed outside request completion");

  // completion always presents a result
  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    done |=> m_axis_tvalid)
    else $error("completed request left no result");
`endif

endmodule

// File: tb/integer_set_table_checker.sv
`timescale 1ns / 100ps
// Checker for integer_set_table: watches both stream channels, keeps its own model of
// the set and compares every result transfer with the oldest expected one.
// Depends on ist_pkg.
module integer_set_table_checker
  import ist_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // value[31:0], position[37:32]
  input  logic [1:0]  s_axis_tuser,   // kind[1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,   // found_position[5:0], read_value[37:6], count[44:38]
  input  logic [2:0]  m_axis_tuser,   // status[2:0]
  output int          pending,
  output int          fail_count
);

  typedef struct {
    status_t            status;
    logic [5:0]         found_position;
    logic signed [31:0] read_value;
    logic [6:0]         count;
  } answer_t;

  // shadow copy of the set, in insertion order
  logic signed [31:0] slots [CAPACITY];
  int                 n_held;
  answer_t            answers_due [$];
  int                 mismatches;

  assign fail_count = mismatches;

  initial begin
    n_held     = 0;
    mismatches = 0;
    pending    = 0;
  end

  // Applies one request to the shadow set and returns the answer it should give.
  function automatic answer_t apply_request(kind_t k, logic signed [31:0] v, logic [5:0] p);
    answer_t a;
    int      hit;
    int      i;
    a.status         = ST_OK;
    a.found_position = '0;
    a.read_value     = '0;
    hit = -1;
    for (i = 0; i < n_held; i++)
      if (hit < 0 && slots[i] == v) hit = i;
    case (k)
      KIND_INSERT: begin
        if (hit >= 0) a.status = ST_PRESENT;       // presence wins over full
        else if (n_held >= CAPACITY) a.status = ST_FULL;
        else begin
          slots[n_held] = v;
          n_held++;
        end
      end
      KIND_REMOVE: begin
        if (n_held == 0) a.status = ST_EMPTY;
        else if (hit < 0) a.status = ST_NOT_FOUND;
        else begin
          // close the gap: later entries move down one place
          for (i = hit; i < n_held - 1; i++) slots[i] = slots[i + 1];
          n_held--;
        end
      end
      KIND_FIND: begin
        if (hit >= 0) a.found_position = 6'(hit);
        else a.status = ST_NOT_FOUND;
      end
      default: begin
        if (int'(p) < n_held) a.read_value = slots[p];
        else a.status = ST_BAD_POS;
      end
    endcase
    a.count = 7'(n_held);
    return a;
  endfunction

  always @(posedge clk) begin : watch
    answer_t got;
    answer_t want;
    if (rst) begin
      n_held = 0;
      answers_due.delete();
    end else begin
      // result side first, so a transfer always meets the answer queued before it
      if (m_axis_tvalid && m_axis_tready) begin
        got.status         = status_t'(m_axis_tuser);
        got.found_position = m_axis_tdata[5:0];
        got.read_value     = m_axis_tdata[37:6];
        got.count          = m_axis_tdata[44:38];
        if (answers_due.size() == 0) begin
          $error("result transfer with none outstanding: status %0d", got.status);
          mismatches++;
        end else begin
          want = answers_due.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
          end
          if (got.found_position !== want.found_position) begin
            $error("found_position: expected %0d, got %0d",
                   want.found_position, got.found_position);
            mismatches++;
          end
          if (got.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
            mismatches++;
          end
          if (got.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, got.count);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        answers_due.push_back(apply_request(kind_t'(s_axis_tuser), s_axis_tdata[31:0],
                                            s_axis_tdata[37:32]));
    end
    pending <= answers_due.size();
  end

endmodule

// File: tb/integer_set_table_tb.sv
`timescale 1ns / 100ps
// Testbench top for integer_set_table: drives requests with random gaps and a stalling
// sink, and gives the verdict from the checker's mismatch count.
// Depends on ist_pkg, integer_set_table, integer_set_table_checker.
module integer_set_table_tb;
  import ist_pkg::*;

  localparam int CAPACITY  = 64;
  localparam int POOL_SIZE = 80;
  localparam int N_RANDOM  = 650;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // value[31:0], position[37:32]
  logic [1:0]  s_axis_tuser = '0;   // kind[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // found_position[5:0], read_value[37:6], count[44:38]
  logic [2:0]  m_axis_tuser;        // status[2:0]

  int          pending;
  int          fail_count;

  // calm: no source gaps and no sink stalls for the current stretch
  logic        calm = 1'b0;
  int          hold_left = 0;
  int          sent = 0;
  logic [31:0] pool [POOL_SIZE];

  integer_set_table #(.CAPACITY(CAPACITY)) u_dut (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  integer_set_table_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .pending, .fail_count
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic logic [31:0] pool_pick();
    return pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // read positions lean towards the low end, where entries usually live
  function automatic logic [5:0] pos_pick();
    if ($urandom_range(0, 1) != 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, 15));
  endfunction

  // Sink: ready most of the time, with random stall bursts.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!calm && $urandom_range(0, 99) < 35) hold_left <= pick_gap();
    end
  end

  // One request transfer, preceded by an optional idle gap carrying junk data.
  task automatic send_req(input kind_t k, input logic [31:0] v, input logic [5:0] p);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 40'({$urandom(), $urandom()});
      s_axis_tuser  <= 2'($urandom_range(0, 3));
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, p, v};
    s_axis_tuser  <= k;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int          mode;
    int          len;
    int          walk;
    int          j;
    int          r;
    logic [31:0] v;

    // value pool: the extremes and a few small numbers, the rest random
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7fff_ffff;
    pool[2] = 32'h0000_0000;
    pool[3] = 32'hffff_ffff;
    for (j = 4; j < 8; j++) pool[j] = 32'(j - 2);
    for (j = 8; j < POOL_SIZE; j++) pool[j] = $urandom();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-set cases, extremes, duplicates, shifting removal.
    send_req(KIND_REMOVE, 32'd5, 6'd0);          // remove from empty set
    send_req(KIND_FIND,   32'd5, 6'd0);          // find in empty set
    send_req(KIND_READ,   32'd0, 6'd0);          // read of empty set
    send_req(KIND_READ,   32'd0, 6'd63);
    send_req(KIND_INSERT, 32'h8000_0000, 6'd0);
    send_req(KIND_INSERT, 32'h7fff_ffff, 6'd0);
    send_req(KIND_INSERT, 32'h0000_0000, 6'd0);
    send_req(KIND_INSERT, 32'hffff_ffff, 6'd63);  // position ignored on insert
    send_req(KIND_INSERT, 32'h8000_0000, 6'd0);  // already present
    send_req(KIND_FIND,   32'h7fff_ffff, 6'd0);
    send_req(KIND_FIND,   32'hffff_ffff, 6'd0);
    send_req(KIND_FIND,   32'd12345, 6'd0);      // absent value
    send_req(KIND_READ,   32'd0, 6'd0);
    send_req(KIND_READ,   32'hffff_ffff, 6'd3);
    send_req(KIND_READ,   32'd0, 6'd4);          // just past the count
    send_req(KIND_REMOVE, 32'd777, 6'd0);        // absent value
    send_req(KIND_REMOVE, 32'h8000_0000, 6'd0);  // head removal shifts all down
    send_req(KIND_READ,   32'd0, 6'd0);
    send_req(KIND_FIND,   32'hffff_ffff, 6'd0);
    send_req(KIND_REMOVE, 32'hffff_ffff, 6'd0);  // tail removal
    send_req(KIND_READ,   32'd0, 6'd2);
    send_req(KIND_REMOVE, 32'h7fff_ffff, 6'd0);
    send_req(KIND_REMOVE, 32'h0000_0000, 6'd0);  // back to empty
    send_req(KIND_REMOVE, 32'h0000_0000, 6'd0);

    // Random phases; the first one fills the set so the full case is reached.
    mode = 0;
    while (sent < 24 + N_RANDOM) begin
      calm = ($urandom_range(0, 4) == 0);
      walk = $urandom_range(0, POOL_SIZE - 1);
      case (mode)
        0:       len = $urandom_range(70, 110);
        1:       len = $urandom_range(60, 120);
        2:       len = $urandom_range(30, 80);
        default: len = $urandom_range(5, 12);
      endcase
      for (j = 0; j < len && sent < 24 + N_RANDOM; j++) begin
        r = $urandom_range(0, 99);
        case (mode)
          0: begin  // fill: mostly inserts walking the pool
            if (r < 80) send_req(KIND_INSERT, pool[(walk + j) % POOL_SIZE], pos_pick());
            else if (r < 90) send_req(KIND_FIND, pool_pick(), pos_pick());
            else send_req(KIND_READ, pool_pick(), pos_pick());
          end
          1: begin  // drain: mostly removes, down to empty and past it
            if (r < 45) send_req(KIND_REMOVE, pool[(walk + j) % POOL_SIZE], pos_pick());
            else if (r < 75) send_req(KIND_REMOVE, pool_pick(), pos_pick());
            else if (r < 88) send_req(KIND_FIND, pool_pick(), pos_pick());
            else send_req(KIND_READ, pool_pick(), pos_pick());
          end
          2: begin  // mixed operations on pool values, a few fresh ones
            v = (r < 10) ? $urandom() : pool_pick();
            send_req(kind_t'(2'($urandom_range(0, 3))), v, pos_pick());
          end
          default: begin  // noise: every field random
            send_req(kind_t'(2'($urandom_range(0, 3))), $urandom(), 6'($urandom_range(0, 63)));
          end
        endcase
      end
      mode = $urandom_range(0, 3);
    end

    s_axis_tvalid <= 1'b0;
    calm = 1'b0;
    // let the checker count the last request before pending is polled
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
